[sv/spd_pkg.sv]
`default_nettype none
package spd_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int OFF_W = 13;
  localparam int LEN_W = 12;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;
  // wide enough for header + slot area + one more slot + a record
  localparam int ACC_W = 15;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_REM,
    OP_PACK,
    OP_READ
  } cell_op_e;

  // one directory entry
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } entry_t;

  // item traveling along the chain; off carries the running position when repacking
  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } bus_t;

  // control broadcast to every cell
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    entry_t           wr;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/spd_cell.sv]
`default_nettype none
module spd_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [spd_pkg::IDX_W-1:0] cell_idx_i,
  input  wire spd_pkg::cell_ctrl_t      ctrl_i,
  input  wire spd_pkg::entry_t          lo_i,
  input  wire spd_pkg::entry_t          hi_i,
  output spd_pkg::entry_t               entry_o,
  input  wire spd_pkg::bus_t            bus_i,
  output spd_pkg::bus_t                 bus_o
);

  spd_pkg::entry_t entry_q, entry_d;
  spd_pkg::bus_t   bus_q, bus_d;
  logic [spd_pkg::OFF_W-1:0] pos;

  // shift, write, repack or tap this entry
  always_comb begin
    entry_d = entry_q;
    bus_d   = bus_i;
    pos     = '0;
    unique case (ctrl_i.op)
      spd_pkg::OP_INS: begin
        if (cell_idx_i > ctrl_i.idx) begin
          entry_d = lo_i;
        end else if (cell_idx_i == ctrl_i.idx) begin
          entry_d = ctrl_i.wr;
        end
      end
      spd_pkg::OP_REM: begin
        if (cell_idx_i >= ctrl_i.idx) begin
          entry_d = hi_i;
        end
      end
      spd_pkg::OP_PACK: begin
        if (bus_i.vld && ({1'b0, cell_idx_i} < ctrl_i.cnt)) begin
          pos = ({1'b0, entry_q.len} <= bus_i.off) ? bus_i.off - {1'b0, entry_q.len} : '0;
          entry_d.off = pos;
          bus_d.off   = pos;
        end
      end
      spd_pkg::OP_READ: begin
        if (bus_i.vld && (cell_idx_i == ctrl_i.idx)) begin
          bus_d.off = entry_q.off;
          bus_d.len = entry_q.len;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // advance the chain item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else begin
      bus_q <= bus_d;
    end
  end

  assign entry_o = entry_q;
  assign bus_o   = bus_q;

endmodule
`default_nettype wire

[sv/slotted_page_directory_unit.sv]
`default_nettype none
// Channel  | dir | fields (lowest bit first)
// s_axis   | in  | command[2:0] slot_index[12:3] record_length[24:13]
// m_axis   | out | status[1:0] result_index[11:2] record_offset[24:12]
//          |     | record_length_out[36:25] slot_count[46:37] free_bytes[58:47]
//
// One command at a time. Clear, append, insert, failed commands and the removal
// of the only remaining slot go from accept through the execute state straight to
// the result. Read and a remove that leaves slots send one item down the chain of
// slot cells, one cell per cycle, and give their result once it leaves the last cell.
// Reset empties the directory; slot entries hold no reset value.
// The input is not ready while a command runs or its result waits to be taken.
module slotted_page_directory_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // command, slot_index, record_length
  input  wire logic [spd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status, result_index, record_offset, record_length_out, slot_count, free_bytes
  output logic [spd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [spd_pkg::CMD_W-1:0] cmd_q;
  logic [spd_pkg::IDX_W-1:0] idx_q;
  logic [spd_pkg::LEN_W-1:0] len_q;
  logic [spd_pkg::CNT_W-1:0] count_q, count_d;
  logic [spd_pkg::OFF_W-1:0] ras_q, ras_d;
  logic [spd_pkg::ST_W-1:0]  status_q, status_d;
  logic [spd_pkg::IDX_W-1:0] ridx_q, ridx_d;
  logic [spd_pkg::OFF_W-1:0] roff_q, roff_d;
  logic [spd_pkg::LEN_W-1:0] rlen_q, rlen_d;
  logic                      inj_q;

  spd_pkg::cell_ctrl_t ctrl;
  spd_pkg::bus_t       inj;
  spd_pkg::entry_t     entries [spd_pkg::MAX_SLOTS];
  spd_pkg::bus_t       buses   [spd_pkg::MAX_SLOTS];

  logic [spd_pkg::IDX_W-1:0] idx_eff;
  logic [spd_pkg::ACC_W-1:0] front, need;
  logic [spd_pkg::OFF_W-1:0] new_off;
  logic                      room;
  logic [spd_pkg::ACC_W-1:0] free_w;
  spd_pkg::bus_t             tail;

  assign tail = buses[spd_pkg::MAX_SLOTS-1];

  // space checks against the current directory
  always_comb begin
    front = spd_pkg::ACC_W'(spd_pkg::HEADER_BYTES)
          + spd_pkg::ACC_W'(count_q) * spd_pkg::ACC_W'(spd_pkg::SLOT_BYTES);
    need  = front + spd_pkg::ACC_W'(spd_pkg::SLOT_BYTES) + spd_pkg::ACC_W'(len_q);
    room  = (count_q < spd_pkg::CNT_W'(spd_pkg::MAX_SLOTS))
         && (spd_pkg::ACC_W'(ras_q) >= need);
    new_off = ras_q - spd_pkg::OFF_W'(len_q);
    idx_eff = (cmd_q == spd_pkg::CMD_APPEND) ? count_q[spd_pkg::IDX_W-1:0] : idx_q;
    free_w  = (spd_pkg::ACC_W'(ras_q) >= front) ? spd_pkg::ACC_W'(ras_q) - front : '0;
  end

  // sequence one command and drive the cell row
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ras_d    = ras_q;
    status_d = status_q;
    ridx_d   = ridx_q;
    roff_d   = roff_q;
    rlen_d   = rlen_q;
    ctrl.op  = spd_pkg::OP_NONE;
    ctrl.idx = idx_eff;
    ctrl.cnt = count_q;
    ctrl.wr.off = new_off;
    ctrl.wr.len = len_q;
    inj.vld  = inj_q;
    inj.off  = (cmd_q == spd_pkg::CMD_REMOVE) ? spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES) : '0;
    inj.len  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = spd_pkg::ST_DONE;
        ridx_d   = '0;
        roff_d   = '0;
        rlen_d   = '0;
        state_d  = S_OUT;
        unique case (cmd_q)
          spd_pkg::CMD_CLEAR: begin
            count_d = '0;
            ras_d   = spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES);
          end
          spd_pkg::CMD_APPEND, spd_pkg::CMD_INSERT: begin
            if ({1'b0, idx_eff} > count_q) begin
              status_d = spd_pkg::ST_RANGE;
            end else if (!room) begin
              status_d = spd_pkg::ST_NOSPACE;
            end else begin
              ctrl.op = spd_pkg::OP_INS;
              count_d = count_q + 1'b1;
              ras_d   = new_off;
              ridx_d  = idx_eff;
              roff_d  = new_off;
              rlen_d  = len_q;
            end
          end
          spd_pkg::CMD_REMOVE: begin
            if ({1'b0, idx_q} >= count_q) begin
              status_d = spd_pkg::ST_RANGE;
            end else begin
              ctrl.op = spd_pkg::OP_REM;
              count_d = count_q - 1'b1;
              ridx_d  = idx_q;
              if (count_q == spd_pkg::CNT_W'(1)) begin
                ras_d = spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES);
              end else begin
                state_d = S_SWEEP;
              end
            end
          end
          spd_pkg::CMD_READ: begin
            if ({1'b0, idx_q} >= count_q) begin
              status_d = spd_pkg::ST_RANGE;
            end else begin
              ridx_d  = idx_q;
              state_d = S_SWEEP;
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        ctrl.op = (cmd_q == spd_pkg::CMD_REMOVE) ? spd_pkg::OP_PACK : spd_pkg::OP_READ;
        if (tail.vld) begin
          state_d = S_OUT;
          if (cmd_q == spd_pkg::CMD_REMOVE) begin
            ras_d = tail.off;
          end else begin
            roff_d = tail.off;
            rlen_d = tail.len;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold state and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ras_q    <= spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES);
      inj_q    <= 1'b0;
      status_q <= '0;
      ridx_q   <= '0;
      roff_q   <= '0;
      rlen_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ras_q    <= ras_d;
      inj_q    <= (state_q == S_EXEC) && (state_d == S_SWEEP);
      status_q <= status_d;
      ridx_q   <= ridx_d;
      roff_q   <= roff_d;
      rlen_q   <= rlen_d;
    end
  end

  // capture the accepted item
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[2:0];
      idx_q <= s_axis_tdata[12:3];
      len_q <= s_axis_tdata[24:13];
    end
  end

  // row of slot cells
  for (genvar i = 0; i < spd_pkg::MAX_SLOTS; i++) begin : g_cell
    spd_pkg::entry_t lo, hi;
    spd_pkg::bus_t   bin;
    if (i == 0) begin : g_first
      assign lo  = '0;
      assign bin = inj;
    end else begin : g_mid
      assign lo  = entries[i-1];
      assign bin = buses[i-1];
    end
    if (i == spd_pkg::MAX_SLOTS - 1) begin : g_last
      assign hi = '0;
    end else begin : g_up
      assign hi = entries[i+1];
    end
    spd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (spd_pkg::IDX_W'(i)),
      .ctrl_i     (ctrl),
      .lo_i       (lo),
      .hi_i       (hi),
      .entry_o    (entries[i]),
      .bus_i      (bin),
      .bus_o      (buses[i])
    );
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'd0, free_w[spd_pkg::LEN_W-1:0], count_q[spd_pkg::IDX_W-1:0],
                          rlen_q, roff_q, ridx_q, status_q};

endmodule
`default_nettype wire
